// ----- hdl/ias_pkg.sv -----
// Package for the interval activity selector.
// Holds default parameters and the sequencer state type; no dependencies.
package ias_pkg;
  localparam int MaxMeetingsDef = 64;
  localparam int TimeWidthDef   = 32;
  localparam int NumWidth       = 7;
  localparam int FieldWidth     = 32;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } state_t;
endpackage

// ----- hdl/ias_if.sv -----
// Valid/ready channel interfaces for the interval activity selector.
// Depends on ias_pkg for field widths.
interface ias_in_if import ias_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [FieldWidth-1:0] start_time;
  logic signed [FieldWidth-1:0] finish_time;
  logic                         last_interval;
  modport source (output valid, start_time, finish_time, last_interval, input ready);
  modport sink   (input valid, start_time, finish_time, last_interval, output ready);
endinterface

interface ias_out_if import ias_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [NumWidth-1:0] interval_number;
  logic                last_selected;
  logic                overflow;
  modport source (output valid, interval_number, last_selected, overflow, input ready);
  modport sink   (input valid, interval_number, last_selected, overflow, output ready);
endinterface

// ----- hdl/interval_activity_selector_core.sv -----
// Interval activity selector, top level (greedy earliest-finish selection).
// Depends on ias_pkg and the channel interfaces in ias_if.sv.
//
//   channel   | dir | payload
//   in_ch     | in  | start_time, finish_time, last_interval
//   out_ch    | out | interval_number, last_selected, overflow
//
// Load: one interval transaction per cycle, written into the time memory.
// Select: each scan pass reads all n loaded entries (registered memory read)
//   and picks the next interval in (finish, arrival) order whose start is
//   past the current finish.
// A stalled output holds the walk. No input is taken until the final result
//   is accepted.
// Reset (rst, synchronous) clears control state only; memory holds no reset.
module interval_activity_selector_core
  import ias_pkg::*;
#(
  parameter int MAX_MEETINGS = MaxMeetingsDef,
  parameter int TIME_WIDTH   = TimeWidthDef
) (
  input  logic       clk,
  input  logic       rst,
  ias_in_if.sink     in_ch,
  ias_out_if.source  out_ch
);
  localparam int AW = $clog2(MAX_MEETINGS);
  localparam int CW = $clog2(MAX_MEETINGS + 1);

  // Time store: one memory holds {start, finish} per arrival index.
  logic [2*TIME_WIDTH-1:0] time_mem [MAX_MEETINGS];

  state_t state, state_next;
  logic [CW-1:0] loaded_count;
  logic          overflow_seen;

  // Scan pipeline: address issue, then registered data in the next cycle
  logic [CW-1:0]           scan_addr;
  logic                    rd_valid;
  logic [AW-1:0]           rd_idx;
  logic [2*TIME_WIDTH-1:0] t_rdata;

  // Current selection (last one found) and best candidate of this pass
  logic                         have_cur;
  logic [AW-1:0]                cur_idx;
  logic signed [TIME_WIDTH-1:0] cur_finish;
  logic                         found;
  logic [AW-1:0]                best_idx;
  logic signed [TIME_WIDTH-1:0] best_finish;

  // Result register, held while out_ch is stalled
  logic [NumWidth-1:0] res_num;
  logic                res_last;

  logic issue;
  logic scan_end;

  wire in_fire  = in_ch.valid && in_ch.ready;
  wire out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready  = (state == ST_LOAD);
  assign out_ch.valid = (state == ST_EMIT);

  wire signed [TIME_WIDTH-1:0] rd_start  = t_rdata[2*TIME_WIDTH-1:TIME_WIDTH];
  wire signed [TIME_WIDTH-1:0] rd_finish = t_rdata[TIME_WIDTH-1:0];

  // Candidate must sort after the current selection (finish, then arrival)
  // and start strictly after its finish. The very first pass takes all.
  wire eligible = !have_cur ||
                  ((rd_start > cur_finish) &&
                   ((rd_finish > cur_finish) ||
                    ((rd_finish == cur_finish) && (rd_idx > cur_idx))));
  // Entries come in arrival order, so a strict compare keeps the lower index.
  wire better = !found || (rd_finish < best_finish);

  // Memory write on load, registered read during scans
  always_ff @(posedge clk) begin
    if (in_fire && loaded_count < CW'(MAX_MEETINGS)) begin
      time_mem[loaded_count[AW-1:0]] <= {TIME_WIDTH'(in_ch.start_time),
                                         TIME_WIDTH'(in_ch.finish_time)};
    end
    t_rdata <= time_mem[scan_addr[AW-1:0]];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and scan strobes
  always_comb begin
    state_next = state;
    issue      = 1'b0;
    scan_end   = 1'b0;
    case (state)
      ST_LOAD: begin
        if (in_fire && in_ch.last_interval) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_addr < loaded_count) begin
          issue = 1'b1;
        end else if (!rd_valid) begin
          // every entry evaluated; first pass only seeds the walk
          scan_end = 1'b1;
          if (have_cur) state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_fire) state_next = res_last ? ST_LOAD : ST_SCAN;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count  <= '0;
      overflow_seen <= 1'b0;
      scan_addr     <= '0;
      rd_valid      <= 1'b0;
      have_cur      <= 1'b0;
      found         <= 1'b0;
    end else begin
      if (in_fire) begin
        if (loaded_count < CW'(MAX_MEETINGS)) loaded_count <= loaded_count + CW'(1);
        else overflow_seen <= 1'b1;
        if (in_ch.last_interval) begin
          scan_addr <= '0;
          found     <= 1'b0;
          have_cur  <= 1'b0;
        end
      end
      rd_valid <= issue;
      if (issue) begin
        rd_idx    <= scan_addr[AW-1:0];
        scan_addr <= scan_addr + CW'(1);
      end
      if (rd_valid && eligible && better) begin
        found       <= 1'b1;
        best_idx    <= rd_idx;
        best_finish <= rd_finish;
      end
      if (scan_end) begin
        // current selection goes out; it is final when nothing follows it
        if (have_cur) begin
          res_num  <= NumWidth'(cur_idx) + NumWidth'(1);
          res_last <= !found;
        end
        if (found) begin
          cur_idx    <= best_idx;
          cur_finish <= best_finish;
          have_cur   <= 1'b1;
        end
        if (!have_cur) begin
          scan_addr <= '0;
          found     <= 1'b0;
        end
      end
      if (out_fire) begin
        if (res_last) begin
          loaded_count  <= '0;
          overflow_seen <= 1'b0;
        end else begin
          scan_addr <= '0;
          found     <= 1'b0;
        end
      end
    end
  end

  assign out_ch.interval_number = res_num;
  assign out_ch.last_selected   = res_last;
  assign out_ch.overflow        = overflow_seen;
endmodule

// ----- bench/tb_scoreboard.sv -----
// Scoreboard class for the interval activity selector bench.
// Predicts greedy earliest-finish selection per batch; depends on ias_pkg.
`timescale 1ns / 100ps

package tb_scoreboard_pkg;
  import ias_pkg::*;

  typedef struct packed {
    logic [NumWidth-1:0] number;
    logic                last;
    logic                ovf;
  } selection_t;

  class selection_board;
    int                 capacity;
    logic signed [31:0] starts[$];
    logic signed [31:0] finishes[$];
    bit                 dropped;
    selection_t         pending[$];
    int                 errors;

    function new(int cap);
      capacity = cap;
      errors = 0;
      dropped = 0;
    endfunction

    // Note one accepted interval; a last-marked one closes the batch.
    function void note_interval(logic signed [31:0] s, logic signed [31:0] f, logic last);
      int order[$];
      int j;
      int k;
      logic signed [31:0] bound;
      selection_t r;
      if (starts.size() < capacity) begin
        starts = {starts, s};
        finishes = {finishes, f};
      end else begin
        dropped = 1;
      end
      if (!last) return;
      // stable insertion by finish time
      for (int i = 0; i < starts.size(); i++) begin
        j = order.size();
        while (j > 0 && finishes[order[j-1]] > finishes[i]) j--;
        order.insert(j, i);
      end
      bound = finishes[order[0]];
      r.number = NumWidth'(order[0] + 1);
      r.last = 0;
      r.ovf = dropped;
      pending = {pending, r};
      for (int i = 1; i < order.size(); i++) begin
        k = order[i];
        if (starts[k] > bound) begin
          r.number = NumWidth'(k + 1);
          pending = {pending, r};
          bound = finishes[k];
        end
      end
      pending[pending.size()-1].last = 1;
      starts.delete();
      finishes.delete();
      dropped = 0;
    endfunction

    function void check_selection(logic [NumWidth-1:0] num, logic last, logic ovf);
      selection_t e;
      if (pending.size() == 0) begin
        $error("unexpected selection %0d", num);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (num !== e.number) begin
        $error("interval_number exp %0d got %0d", e.number, num);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_selected exp %0b got %0b", e.last, last);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $error("overflow exp %0b got %0b", e.ovf, ovf);
        errors++;
      end
    endfunction
  endclass
endpackage

// ----- bench/tb.sv -----
// Top-level bench for interval_activity_selector_core.
// Depends on ias_pkg, ias_if.sv and tb_scoreboard.sv.
`timescale 1ns / 100ps

module tb;
  import ias_pkg::*;
  import tb_scoreboard_pkg::*;

  localparam int Cap = MaxMeetingsDef;
  localparam int WatchLimit = 3000; // longest quiet spell: receiver hold-off plus two scans

  logic clk;
  logic rst;
  ias_in_if  in_ch();
  ias_out_if out_ch();

  interval_activity_selector_core u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  selection_board board;
  int  idle_cycles = 0;
  bit  hold_req;    // stimulus asks for a long receiver hold-off
  bit  sink_held;   // receiver is in its hold-off

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly short, sometimes long.
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic logic signed [31:0] rand_time();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $urandom;
      default: return $signed($urandom_range(0, 60)) - 20;
    endcase
  endfunction

  // Send one interval transaction; valid stays high across back-to-back items.
  task automatic send_interval(logic signed [31:0] s, logic signed [31:0] f, logic last,
                               bit no_gap = 0);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.start_time <= s;
    in_ch.finish_time <= f;
    in_ch.last_interval <= last;
    do @(posedge clk); while (!in_ch.ready);
    board.note_interval(s, f, last);
    @(negedge clk);
  endtask

  task automatic send_batch(int n, bit no_gap = 0);
    logic signed [31:0] s;
    for (int i = 1; i <= n; i++) begin
      s = rand_time();
      // mostly well-formed: finish at or after start
      send_interval(s, ($urandom_range(0, 4) == 0) ? rand_time()
                    : s + $signed($urandom_range(0, 15)), i == n, no_gap);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  // Receiver: random ready, with one long hold-off counted here.
  initial begin
    int g;
    out_ch.ready = 0;
    sink_held = 0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        sink_held = 1;
        out_ch.ready <= 0;
        repeat (300) @(negedge clk);
        sink_held = 0;
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_ch.ready <= 0;
          repeat (g) @(negedge clk);
        end
        out_ch.ready <= 1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  // Check results and count idle cycles at each rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        board.check_selection(out_ch.interval_number, out_ch.last_selected, out_ch.overflow);
        idle_cycles <= 0;
      end else if (in_ch.valid && in_ch.ready) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Watchdog
  initial begin
    wait (idle_cycles >= WatchLimit);
    $display("tb failed");
    $finish;
  end

  // Stimulus
  initial begin
    int sent;
    board = new(Cap);
    hold_req = 0;
    rst = 1;
    in_ch.valid = 0;
    in_ch.start_time = 0;
    in_ch.finish_time = 0;
    in_ch.last_interval = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: single interval, extremes, ties, touching ends, overlap
    send_interval(32'sh8000_0000, 32'sh7fff_ffff, 1);
    send_interval(32'sh7fff_ffff, 32'sh8000_0000, 1);
    send_interval(0, 5, 0);
    send_interval(5, 9, 0);        // start equals prior finish: rejected
    send_interval(6, 9, 0);        // ties on finish
    send_interval(-3, 5, 0);
    send_interval(32'sh8000_0000, 32'sh8000_0000, 0);
    send_interval(32'sh7fff_ffff, 32'sh7fff_ffff, 1);
    send_interval(32'sh5555_5555, 32'shAAAA_AAAA, 0);
    send_interval(32'shAAAA_AAAA, 32'sh5555_5555, 1);
    drain();

    // sink holds off while sender keeps offering: results back up and input stalls
    hold_req = 1;
    wait (sink_held);
    hold_req = 0;
    send_batch(4, 1);
    send_batch(3, 1);
    drain();

    // overflow: capacity plus extra, last dropped too
    for (int i = 0; i < Cap + 3; i++)
      send_interval(rand_time(), rand_time(), i == Cap + 2, 1);
    drain();

    // random batches, mostly small
    sent = 0;
    while (sent < 26) begin
      int n;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
      send_batch(n);
      sent += n;
      if ($urandom_range(0, 3) == 0) drain();
    end
    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
